// ----- design/ascii_frame_deframer_core_assert.svh -----
// Assertion macros for the checker file of the deframer.
`ifndef ASCII_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define ASCII_FRAME_DEFRAMER_CORE_ASSERT_SVH

// Clocked check, masked while reset is applied.
`define AFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is applied.
`define AFD_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/afd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package afd_pkg;

	localparam int MAX_HEADER  = 16;
	localparam int LENGTH_BITS = 16;
	localparam int HDR_CNT_W   = $clog2(MAX_HEADER + 1);
	localparam int LEN_W       = LENGTH_BITS + 1;
	localparam logic [LEN_W-1:0] LEN_CAP = {1'b1, {LENGTH_BITS{1'b0}}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [15:0] MAX_LENGTH_RESET = 16'd4096;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_REPORT  = 2'd2;

	localparam logic [2:0] CLASS_EMPTY = 3'd0;
	localparam logic [2:0] CLASS_CPERR = 3'd1;
	localparam logic [2:0] CLASS_TMSCT = 3'd2;
	localparam logic [2:0] CLASS_TMSTA = 3'd3;
	localparam logic [2:0] CLASS_TMSVR = 3'd4;
	localparam logic [2:0] CLASS_OTHER = 3'd5;

	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_BAD_LENGTH  = 4'd1;
	localparam logic [3:0] ST_NO_COMMA    = 4'd2;
	localparam logic [3:0] ST_NO_STAR     = 4'd3;
	localparam logic [3:0] ST_BAD_HEX     = 4'd4;
	localparam logic [3:0] ST_SUM_MISS    = 4'd5;
	localparam logic [3:0] ST_BAD_END     = 4'd6;
	localparam logic [3:0] ST_HDR_LONG    = 4'd7;
	localparam logic [3:0] ST_TRUNCATED   = 4'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_in_buffer;
	} afd_in_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [7:0]  out_byte;
		logic [2:0]  header_class;
		logic [15:0] payload_length;
		logic [7:0]  received_sum;
		logic [15:0] frame_size;
		logic [3:0]  status;
	} afd_out_t;

endpackage
`default_nettype wire

// ----- design/afd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module afd_front import afd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] max_length,
	input  wire logic        accept,
	input  wire afd_in_t     in_data,
	output logic             push_valid,
	output afd_out_t         push_data
);

	typedef enum logic [9:0] {
		PH_HUNT     = 10'b00_0000_0001,
		PH_HEADER   = 10'b00_0000_0010,
		PH_LENGTH   = 10'b00_0000_0100,
		PH_PAYLOAD  = 10'b00_0000_1000,
		PH_PAYCOMMA = 10'b00_0001_0000,
		PH_STAR     = 10'b00_0010_0000,
		PH_HEX1     = 10'b00_0100_0000,
		PH_HEX2     = 10'b00_1000_0000,
		PH_CR       = 10'b01_0000_0000,
		PH_LF       = 10'b10_0000_0000
	} phase_t;

	localparam logic [3:0][4:0][7:0] NAME_TAB = '{
		'{8'h52, 8'h56, 8'h53, 8'h4D, 8'h54},   // TMSVR
		'{8'h41, 8'h54, 8'h53, 8'h4D, 8'h54},   // TMSTA
		'{8'h54, 8'h43, 8'h53, 8'h4D, 8'h54},   // TMSCT
		'{8'h52, 8'h52, 8'h45, 8'h50, 8'h43}    // CPERR
	};

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	phase_t                 phase_q, phase_n;
	logic [HDR_CNT_W-1:0]   hc_q, hc_n;
	logic [3:0]             flags_q, flags_n;
	logic [LEN_W-1:0]       la_q, la_n;
	logic [LENGTH_BITS-1:0] pc_q, pc_n, pc_inc;
	logic [7:0]             xor_q, xor_n;
	logic [7:0]             hex_q, hex_n;
	logic [15:0]            bc_q, bc_n;
	logic [3:0]             pend_q, pend_n;

	logic [7:0]       b;
	logic [4:0]       hx;
	logic [LEN_W+3:0] prod;
	logic             live, rep, kind_v;
	logic [3:0]       rep_status;
	logic [1:0]       kind;
	logic [2:0]       cls;
	logic [31:0]      la32_n;

	assign b      = in_data.data_byte;
	assign hx     = hex_digit(b);
	assign pc_inc = pc_q + 1'b1;
	assign prod   = ({4'b0, la_q} << 3) + ({4'b0, la_q} << 1)
	              + (LEN_W+4)'(b - 8'h30);

	always_comb begin
		phase_n    = phase_q;
		hc_n       = hc_q;
		flags_n    = flags_q;
		la_n       = la_q;
		pc_n       = pc_q;
		xor_n      = xor_q;
		hex_n      = hex_q;
		bc_n       = bc_q;
		pend_n     = pend_q;
		live       = 1'b0;
		rep        = 1'b0;
		rep_status = ST_OK;
		kind_v     = 1'b0;
		kind       = KIND_HEADER;
		if (accept) begin
			if (phase_q != PH_HUNT && bc_q != 16'hFFFF) bc_n = bc_q + 16'd1;
			unique case (phase_q)
				PH_HUNT: begin
					if (b == CH_DOLLAR) begin
						live    = 1'b1;
						phase_n = PH_HEADER;
						hc_n    = '0;
						flags_n = 4'hF;
						la_n    = '0;
						pc_n    = '0;
						xor_n   = 8'h00;
						hex_n   = 8'h00;
						pend_n  = ST_OK;
						bc_n    = 16'd1;
					end
				end
				PH_HEADER: begin
					live  = 1'b1;
					xor_n = xor_q ^ b;
					if (b == CH_COMMA) begin
						phase_n = PH_LENGTH;
					end else if (32'(hc_q) >= MAX_HEADER) begin
						rep        = 1'b1;
						rep_status = ST_HDR_LONG;
					end else begin
						for (int i = 0; i < 4; i++) begin
							if (hc_q >= HDR_CNT_W'(5) || NAME_TAB[i][hc_q[2:0]] != b)
								flags_n[i] = 1'b0;
						end
						hc_n   = hc_q + 1'b1;
						kind_v = 1'b1;
						kind   = KIND_HEADER;
					end
				end
				PH_LENGTH: begin
					live  = 1'b1;
					xor_n = xor_q ^ b;
					if (b >= 8'h30 && b <= 8'h39) begin
						la_n = (prod > {4'b0, LEN_CAP}) ? LEN_CAP : prod[LEN_W-1:0];
					end else if (b == CH_COMMA) begin
						if (la_q >= LEN_CAP || 32'(la_q) > 32'(max_length)) begin
							rep        = 1'b1;
							rep_status = ST_BAD_LENGTH;
						end else begin
							pc_n    = '0;
							phase_n = (la_q == '0) ? PH_PAYCOMMA : PH_PAYLOAD;
						end
					end else begin
						rep        = 1'b1;
						rep_status = ST_BAD_LENGTH;
					end
				end
				PH_PAYLOAD: begin
					live   = 1'b1;
					xor_n  = xor_q ^ b;
					pc_n   = pc_inc;
					if ({1'b0, pc_inc} >= la_q) phase_n = PH_PAYCOMMA;
					kind_v = 1'b1;
					kind   = KIND_PAYLOAD;
				end
				PH_PAYCOMMA: begin
					live  = 1'b1;
					xor_n = xor_q ^ b;
					if (b == CH_COMMA) begin
						phase_n = PH_STAR;
					end else begin
						rep        = 1'b1;
						rep_status = ST_NO_COMMA;
					end
				end
				PH_STAR: begin
					live = 1'b1;
					if (b == CH_STAR) begin
						phase_n = PH_HEX1;
					end else begin
						rep        = 1'b1;
						rep_status = ST_NO_STAR;
					end
				end
				PH_HEX1: begin
					live = 1'b1;
					if (hx[4]) begin
						hex_n   = {hx[3:0], 4'h0};
						phase_n = PH_HEX2;
					end else begin
						rep        = 1'b1;
						rep_status = ST_BAD_HEX;
					end
				end
				PH_HEX2: begin
					live = 1'b1;
					if (hx[4]) begin
						hex_n   = hex_q | {4'h0, hx[3:0]};
						pend_n  = (xor_q != (hex_q | {4'h0, hx[3:0]})) ? ST_SUM_MISS : ST_OK;
						phase_n = PH_CR;
					end else begin
						rep        = 1'b1;
						rep_status = ST_BAD_HEX;
					end
				end
				PH_CR: begin
					live = 1'b1;
					if (b == CH_CR) begin
						phase_n = PH_LF;
					end else begin
						rep        = 1'b1;
						rep_status = ST_BAD_END;
					end
				end
				PH_LF: begin
					live       = 1'b1;
					rep        = 1'b1;
					rep_status = (b == CH_LF) ? pend_q : ST_BAD_END;
				end
				default: begin
					phase_n = PH_HUNT;
				end
			endcase
			if (live && !rep && in_data.last_in_buffer) begin
				rep        = 1'b1;
				rep_status = ST_TRUNCATED;
			end
			if (rep) phase_n = PH_HUNT;
		end
	end

	assign la32_n = 32'(la_n);

	always_comb begin
		priority if (hc_n == '0)             cls = CLASS_EMPTY;
		else if (hc_n != HDR_CNT_W'(5))      cls = CLASS_OTHER;
		else if (flags_n[0])                 cls = CLASS_CPERR;
		else if (flags_n[1])                 cls = CLASS_TMSCT;
		else if (flags_n[2])                 cls = CLASS_TMSTA;
		else if (flags_n[3])                 cls = CLASS_TMSVR;
		else                                 cls = CLASS_OTHER;
	end

	always_comb begin
		push_valid = rep | kind_v;
		push_data  = '0;
		if (rep) begin
			push_data.item_kind      = KIND_REPORT;
			push_data.header_class   = cls;
			push_data.payload_length = (la32_n > 32'h0000_FFFF) ? 16'hFFFF : la32_n[15:0];
			push_data.received_sum   = hex_n;
			push_data.frame_size     = bc_n;
			push_data.status         = rep_status;
		end else begin
			push_data.item_kind = kind;
			push_data.out_byte  = b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hc_q    <= '0;
			flags_q <= 4'hF;
			la_q    <= '0;
			pc_q    <= '0;
			xor_q   <= 8'h00;
			hex_q   <= 8'h00;
			bc_q    <= 16'd0;
			pend_q  <= ST_OK;
		end else begin
			phase_q <= phase_n;
			hc_q    <= hc_n;
			flags_q <= flags_n;
			la_q    <= la_n;
			pc_q    <= pc_n;
			xor_q   <= xor_n;
			hex_q   <= hex_n;
			bc_q    <= bc_n;
			pend_q  <= pend_n;
		end
	end

endmodule
`default_nettype wire

// ----- design/afd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module afd_queue import afd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	input  wire afd_out_t push_data,
	output logic          full,
	output logic          out_valid,
	input  wire logic     out_ready,
	output afd_out_t      out_data
);

	afd_out_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              push, pop;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = push_valid && !full;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- design/ascii_frame_deframer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ASCII frame deframer: takes one stream byte per request and parses frames of the form
// '$' header ',' decimal length ',' payload ',' '*' two hex digits CR LF. Each header and
// payload byte comes out as its own result request, and every frame ends in one report
// request with status, length, header class, received checksum and frame size. Bytes
// outside a frame are dropped. Throughput is one byte per cycle while in_ready is high;
// the parser front end writes each result straight into a four-entry result queue, which
// lets the consumer stall without holding up the input until four results wait; in_ready
// then drops until one is taken. The queue registers each result before the output sees
// it. max_length may only be written while no frame results are outstanding.
module ascii_frame_deframer_core import afd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire afd_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output afd_out_t         out_data
);

	logic [15:0] max_length_q;
	logic        q_full;
	logic        accept;
	logic        push_valid;
	afd_out_t    push_data;

	// Hold the length limit; reset to the documented default.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_data;
		end
	end

	// Take a byte whenever the queue has room, even if it yields no result.
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Front end: parse state machine, one byte per cycle while in_ready, one result at most.
	afd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_length (max_length_q),
		.accept     (accept),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	// Back end: result queue that drives the output channel.
	afd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (q_full),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule
`default_nettype wire

// ----- design/afd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "ascii_frame_deframer_core_assert.svh"
module afd_checker import afd_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire afd_out_t out_data
);

	logic stalled, is_byte, is_report, ok_report, byte_clean, report_sane;

	assign stalled     = out_valid && !out_ready;
	assign is_byte     = out_valid && (out_data.item_kind == KIND_HEADER
	                   || out_data.item_kind == KIND_PAYLOAD);
	assign is_report   = out_valid && out_data.item_kind == KIND_REPORT;
	assign ok_report   = is_report && out_data.status == ST_OK;
	// Byte requests carry nothing but the byte itself.
	assign byte_clean  = out_data.header_class == CLASS_EMPTY && out_data.payload_length == '0
	                   && out_data.received_sum == '0 && out_data.frame_size == '0
	                   && out_data.status == ST_OK;
	assign report_sane = out_data.out_byte == '0 && out_data.status <= ST_TRUNCATED
	                   && out_data.header_class <= CLASS_OTHER && out_data.frame_size != '0;

	`AFD_ASSERT(a_out_hold, stalled |=> out_valid && $stable(out_data), "output changed in stall")
	`AFD_ASSERT(a_byte_fields, is_byte |-> byte_clean, "byte request carries report fields")
	`AFD_ASSERT(a_report_fields, is_report |-> report_sane, "malformed report request")
	// Shortest good frame: '$' ',' ',' ',' '*' two hex digits CR LF.
	`AFD_ASSERT(a_ok_size, ok_report |-> out_data.frame_size >= 16'd9, "good frame too short")
	`AFD_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind ascii_frame_deframer_core afd_checker u_afd_checker (.*);
`default_nettype wire

// ----- tb/tb_ascii_frame_deframer_core.sv -----
`timescale 1ns / 1ps
module tb_ascii_frame_deframer_core;
	import afd_pkg::*;

	// Parser phases of the local deframing model.
	typedef enum logic [3:0] {
		P_HUNT, P_HEADER, P_LENGTH, P_PAYLOAD, P_PAYCOMMA,
		P_STAR, P_HEX1, P_HEX2, P_EOL_CR, P_EOL_LF
	} frame_phase_t;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	localparam logic [2:0] KNOWN_CLASS [4] = '{CLASS_CPERR, CLASS_TMSCT, CLASS_TMSTA, CLASS_TMSVR};
	localparam afd_out_t NO_WANT = '0;

	// One directed request; rows with typed_want carry a hand-written report.
	typedef struct {
		logic [7:0] data_byte;
		logic       last;
		bit         typed_want;
		afd_out_t   want;
	} directed_row_t;

	string known_names [4] = '{"CPERR", "TMSCT", "TMSTA", "TMSVR"};

	logic     clk;
	logic     arst_n    = 1'b0;
	logic     cfg_we    = 1'b0;
	logic     [15:0] cfg_data = '0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	afd_in_t  in_data   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	afd_out_t out_data;

	// Deframing model state, mirrored from the block's state after reset.
	frame_phase_t phase = P_HUNT;
	int           hdr_len = 0;
	logic [3:0]   name_hits = '1;
	int unsigned  len_value = 0;
	int unsigned  pay_seen = 0;
	logic [7:0]   xor_sum = '0;
	logic [7:0]   hex_sum = '0;
	int           frame_bytes = 0;
	logic [3:0]   held_status = ST_OK;
	logic [15:0]  max_len_cfg = MAX_LENGTH_RESET;

	afd_out_t     deframed_due [$];
	int           mismatch_count = 0;
	int           frame_bytes_sent = 0;
	idle_mode_t   idle_mode = IDLE_NONE;
	int           hold_request = 0;
	int           hold_left = 0;

	directed_row_t directed_rows [25] = '{
		// stray bytes before any frame: drop them, last flag included
		'{8'h41, 1'b0, 1'b0, NO_WANT},
		'{8'hFF, 1'b1, 1'b0, NO_WANT},
		'{8'h00, 1'b0, 1'b0, NO_WANT},
		// start byte that is also the last byte of the buffer
		'{CH_DOLLAR, 1'b1, 1'b1,
			'{KIND_REPORT, 8'h00, CLASS_EMPTY, 16'd0, 8'h00, 16'd1, ST_TRUNCATED}},
		// empty header, then a letter in the length field
		'{CH_DOLLAR, 1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{"x", 1'b0, 1'b1,
			'{KIND_REPORT, 8'h00, CLASS_EMPTY, 16'd0, 8'h00, 16'd3, ST_BAD_LENGTH}},
		// complete frame with zero length and a good checksum
		'{CH_DOLLAR, 1'b0, 1'b0, NO_WANT},
		'{"T", 1'b0, 1'b0, NO_WANT},
		'{"M", 1'b0, 1'b0, NO_WANT},
		'{"S", 1'b0, 1'b0, NO_WANT},
		'{"C", 1'b0, 1'b0, NO_WANT},
		'{"T", 1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{"0", 1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{CH_STAR, 1'b0, 1'b0, NO_WANT},
		'{"4", 1'b0, 1'b0, NO_WANT},
		'{"1", 1'b0, 1'b0, NO_WANT},
		'{CH_CR, 1'b0, 1'b0, NO_WANT},
		'{CH_LF, 1'b0, 1'b0, NO_WANT},
		// buffer ends inside the length field
		'{CH_DOLLAR, 1'b0, 1'b0, NO_WANT},
		'{CH_COMMA, 1'b0, 1'b0, NO_WANT},
		'{"7", 1'b1, 1'b1,
			'{KIND_REPORT, 8'h00, CLASS_EMPTY, 16'd7, 8'h00, 16'd3, ST_TRUNCATED}}
	};

	ascii_frame_deframer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic int hex_digit(input logic [7:0] c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "a" && c <= "f") return c - "a" + 10;
		if (c >= "A" && c <= "F") return c - "A" + 10;
		return -1;
	endfunction

	function automatic logic [2:0] header_class_of();
		int i;
		if (hdr_len == 0) return CLASS_EMPTY;
		if (hdr_len == 5)
			for (i = 0; i < 4; i++)
				if (name_hits[i]) return KNOWN_CLASS[i];
		return CLASS_OTHER;
	endfunction

	// Advance the model by one accepted byte; return 1 when the byte yields a result.
	function automatic bit deframe_byte(input logic [7:0] b, input logic last,
			output afd_out_t res);
		bit         report;
		logic [3:0] code;
		bit         pass_on;
		logic [1:0] kind;
		int         h;
		int         i;
		report = 1'b0;
		code = ST_OK;
		pass_on = 1'b0;
		kind = KIND_HEADER;
		res = '0;
		if (phase == P_HUNT) begin
			if (b != CH_DOLLAR) return 1'b0;
			phase = P_HEADER;
			hdr_len = 0;
			name_hits = '1;
			len_value = 0;
			pay_seen = 0;
			xor_sum = '0;
			hex_sum = '0;
			held_status = ST_OK;
			frame_bytes = 1;
		end else begin
			if (frame_bytes < 65535) frame_bytes++;
			case (phase)
				P_HEADER: begin
					xor_sum ^= b;
					if (b == CH_COMMA) begin
						phase = P_LENGTH;
					end else if (hdr_len >= MAX_HEADER) begin
						report = 1'b1;
						code = ST_HDR_LONG;
					end else begin
						for (i = 0; i < 4; i++)
							if (hdr_len >= 5 || known_names[i][hdr_len] != b) name_hits[i] = 1'b0;
						hdr_len++;
						pass_on = 1'b1;
						kind = KIND_HEADER;
					end
				end
				P_LENGTH: begin
					xor_sum ^= b;
					if (b >= "0" && b <= "9") begin
						len_value = len_value * 10 + (b - "0");
						if (len_value > LEN_CAP) len_value = LEN_CAP;
					end else if (b == CH_COMMA) begin
						if (len_value >= LEN_CAP || len_value > max_len_cfg) begin
							report = 1'b1;
							code = ST_BAD_LENGTH;
						end else begin
							pay_seen = 0;
							phase = (len_value == 0) ? P_PAYCOMMA : P_PAYLOAD;
						end
					end else begin
						report = 1'b1;
						code = ST_BAD_LENGTH;
					end
				end
				P_PAYLOAD: begin
					xor_sum ^= b;
					pay_seen++;
					if (pay_seen >= len_value) phase = P_PAYCOMMA;
					pass_on = 1'b1;
					kind = KIND_PAYLOAD;
				end
				P_PAYCOMMA: begin
					xor_sum ^= b;
					if (b == CH_COMMA) phase = P_STAR;
					else begin
						report = 1'b1;
						code = ST_NO_COMMA;
					end
				end
				P_STAR: begin
					if (b == CH_STAR) phase = P_HEX1;
					else begin
						report = 1'b1;
						code = ST_NO_STAR;
					end
				end
				P_HEX1: begin
					h = hex_digit(b);
					if (h < 0) begin
						report = 1'b1;
						code = ST_BAD_HEX;
					end else begin
						hex_sum = 8'(h << 4);
						phase = P_HEX2;
					end
				end
				P_HEX2: begin
					h = hex_digit(b);
					if (h < 0) begin
						report = 1'b1;
						code = ST_BAD_HEX;
					end else begin
						hex_sum = hex_sum | 8'(h);
						held_status = (xor_sum != hex_sum) ? ST_SUM_MISS : ST_OK;
						phase = P_EOL_CR;
					end
				end
				P_EOL_CR: begin
					if (b == CH_CR) phase = P_EOL_LF;
					else begin
						report = 1'b1;
						code = ST_BAD_END;
					end
				end
				P_EOL_LF: begin
					report = 1'b1;
					code = (b == CH_LF) ? held_status : ST_BAD_END;
				end
				default: begin
					phase = P_HUNT;
					return 1'b0;
				end
			endcase
		end
		// a frame cut short by the end of the buffer reports truncation instead
		if (!report && last) begin
			report = 1'b1;
			code = ST_TRUNCATED;
		end
		if (report) begin
			res.item_kind = KIND_REPORT;
			res.header_class = header_class_of();
			res.payload_length = (len_value > 65535) ? 16'hFFFF : 16'(len_value);
			res.received_sum = hex_sum;
			res.frame_size = 16'(frame_bytes);
			res.status = code;
			phase = P_HUNT;
			return 1'b1;
		end
		if (pass_on) begin
			res.item_kind = kind;
			res.out_byte = b;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// Append the checksum, star and line end to a frame that starts with '$'.
	function automatic void close_frame(ref logic [7:0] seq [$], input bit spoil);
		logic [7:0] sum;
		string      hx;
		int         i;
		sum = '0;
		for (i = 1; i < seq.size(); i++) sum ^= seq[i];
		if (spoil) sum ^= 8'($urandom_range(1, 255));
		hx = $urandom_range(0, 1) ? $sformatf("%02X", sum) : $sformatf("%02x", sum);
		seq = {seq, CH_STAR};
		seq = {seq, hx[0]};
		seq = {seq, hx[1]};
		seq = {seq, CH_CR};
		seq = {seq, CH_LF};
	endfunction

	function automatic bit sender_idles();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(0, 99) < 55;
			IDLE_BOTH:   return $urandom_range(0, 99) < 23;
			default:     return 1'b0;
		endcase
	endfunction

	// Offer one byte, hold it until the request is taken, then log what it must yield.
	// Starts and ends on a rising edge; valid is touched once per time step.
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed_want,
			input afd_out_t want);
		afd_out_t res;
		bit       got;
		while (sender_idles()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, last_in_buffer: last};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		got = deframe_byte(b, last, res);
		if (typed_want) begin
			res = want;
			got = 1'b1;
		end
		if (got) deframed_due = {deframed_due, res};
	endtask

	// Build one frame with random content, mostly well formed, then spoil some of them.
	task automatic send_random_frame();
		logic [7:0] seq [$];
		string      name;
		string      digits;
		int         last_pos;
		int         hsel;
		int         n;
		int         flip;
		int         len;
		int         i;
		int         pos;
		logic [7:0] c;
		last_pos = -1;
		seq = {seq, CH_DOLLAR};
		hsel = $urandom_range(0, 9);
		case (hsel)
			0, 1, 2, 3, 8, 9: begin
				name = known_names[hsel % 4];
				for (i = 0; i < 5; i++) seq = {seq, name[i]};
			end
			4: ;
			5: begin
				// near miss: prefix, one changed letter or one letter too many
				name = known_names[$urandom_range(0, 3)];
				n = $urandom_range(1, 6);
				flip = $urandom_range(0, n);
				for (i = 0; i < n; i++) begin
					c = (i < 5) ? name[i] : "X";
					if (i == flip) c = 8'("A" + $urandom_range(0, 25));
					seq = {seq, c};
				end
			end
			6: begin
				n = $urandom_range(1, MAX_HEADER);
				for (i = 0; i < n; i++) begin
					c = 8'($urandom);
					if (c == CH_COMMA) c = ~c;
					seq = {seq, c};
				end
			end
			default: begin
				n = $urandom_range(MAX_HEADER, MAX_HEADER + 3);
				for (i = 0; i < n; i++) seq = {seq, 8'("A" + $urandom_range(0, 25))};
			end
		endcase
		seq = {seq, CH_COMMA};
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5, 6: begin
				len = $urandom_range(0, 8);
				digits = (len == 0 && $urandom_range(0, 4) == 0) ? "" : $sformatf("%0d", len);
			end
			7: begin
				len = $urandom_range(0, 8);
				digits = $sformatf("%04d", len);
			end
			8: begin
				len = int'(max_len_cfg) + 1;
				digits = $sformatf("%0d", len);
			end
			default: begin
				len = $urandom_range(65536, 999999);
				digits = $sformatf("%0d", len);
			end
		endcase
		for (i = 0; i < digits.len(); i++) seq = {seq, digits[i]};
		seq = {seq, CH_COMMA};
		if (len > 40) len = $urandom_range(0, 8);
		for (i = 0; i < len; i++) seq = {seq, 8'($urandom)};
		seq = {seq, CH_COMMA};
		close_frame(seq, $urandom_range(0, 9) == 0);
		if ($urandom_range(0, 4) == 0) begin
			pos = $urandom_range(1, seq.size() - 1);
			case ($urandom_range(0, 3))
				0: seq[pos] = 8'($urandom);
				1: seq.delete(pos);
				2: begin
					seq = seq[0:pos];
					last_pos = pos;
				end
				default: last_pos = pos;
			endcase
		end else if ($urandom_range(0, 7) == 0) begin
			last_pos = seq.size() - 1;
		end
		for (i = 0; i < seq.size(); i++) send_byte(seq[i], i == last_pos, 1'b0, NO_WANT);
		frame_bytes_sent += seq.size();
		// line noise between frames, sometimes flagged as the end of a buffer
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++)
			send_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_WANT);
	endtask

	task automatic send_frames(input int target);
		frame_bytes_sent = 0;
		while (frame_bytes_sent < target) send_random_frame();
	endtask

	// Drop valid, drain every due result, give the last request time to settle,
	// then load a new max_length and switch the idling pattern.
	task automatic settle_and_configure(input logic [15:0] value, input idle_mode_t mode);
		in_valid <= 1'b0;
		while (deframed_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		max_len_cfg = value;
		cfg_we <= 1'b0;
		idle_mode = mode;
	endtask

	// Receiver side: random stalls by mode, plus long hold-offs on request.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_RECEIVER: out_ready <= $urandom_range(0, 99) >= 55;
				IDLE_BOTH:     out_ready <= $urandom_range(0, 99) >= 23;
				default:       out_ready <= 1'b1;
			endcase
		end
	end

	// Compare each taken result with the oldest due one, field by field.
	always @(posedge clk) begin
		afd_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (deframed_due.size() == 0) begin
				$display("%0t: result with none due, expected nothing, actual %p", $time,
					out_data);
				mismatch_count++;
			end else begin
				want = deframed_due.pop_front();
				check_field("item_kind", want.item_kind, out_data.item_kind);
				check_field("out_byte", want.out_byte, out_data.out_byte);
				check_field("header_class", want.header_class, out_data.header_class);
				check_field("payload_length", want.payload_length, out_data.payload_length);
				check_field("received_sum", want.received_sum, out_data.received_sum);
				check_field("frame_size", want.frame_size, out_data.frame_size);
				check_field("status", want.status, out_data.status);
			end
		end
	end

	initial begin
		logic [7:0] big [$];
		string      head;
		int         i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows at the reset value of max_length, no idling.
		for (i = 0; i < 25; i++)
			send_byte(directed_rows[i].data_byte, directed_rows[i].last,
				directed_rows[i].typed_want, directed_rows[i].want);

		// Widest max_length: a frame that announces the largest length and is cut
		// off by the end of the buffer a few payload bytes in, then random frames.
		settle_and_configure(16'hFFFF, IDLE_NONE);
		big = {big, CH_DOLLAR};
		head = "TMSVR,65535,";
		for (i = 0; i < head.len(); i++) big = {big, head[i]};
		for (i = 0; i < 3; i++) big = {big, 8'($urandom)};
		for (i = 0; i < big.size(); i++) send_byte(big[i], i == big.size() - 1, 1'b0, NO_WANT);
		big.delete();
		send_frames(230);

		// Zero max_length: only empty payloads pass; sender idles.
		settle_and_configure(16'h0000, IDLE_SENDER);
		send_frames(270);

		// Small max_length; open with a long receiver hold-off so the result
		// queue fills and in_ready drops while bytes keep coming.
		settle_and_configure(16'($urandom_range(1, 30)), IDLE_RECEIVER);
		hold_request = 400;
		send_frames(270);

		// Reset value again with both sides idling; pause the sender midway
		// until every due result has come out.
		settle_and_configure(MAX_LENGTH_RESET, IDLE_BOTH);
		send_frames(140);
		in_valid <= 1'b0;
		while (deframed_due.size() != 0) @(posedge clk);
		@(posedge clk);
		send_frames(140);

		in_valid <= 1'b0;
		while (deframed_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
